FILE: sv/wedet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedet_pkg
// shared sizes, register codes and record types of the onset detector
// ----------------------------------------------------------------------------
package wedet_pkg;

    // channel and window geometry
    localparam int CHANNELS  = 3;
    localparam int WINDOW    = 5;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DL_DEPTH  = CHANNELS * WINDOW;
    localparam int DL_AW     = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;

    // field widths
    localparam int IN_CH_W   = 2;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 17;
    localparam int SUM_RAW_W = $clog2(WINDOW * 32768 + 1);
    localparam int SUM_W     = (SUM_RAW_W > MAG_W) ? SUM_RAW_W : MAG_W;
    localparam int THR_W     = 18;
    localparam int OSUM_W    = 18;
    localparam int CMP_W     = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int CNT_W     = 32;

    // configuration port
    localparam int CFG_DW    = 32;
    localparam int CFG_IW    = 1;
    localparam logic [CFG_IW-1:0] REG_SUM_THRESHOLD = 1'd0;
    localparam logic [CFG_IW-1:0] REG_DEBOUNCE_GAP  = 1'd1;
    localparam logic [THR_W-1:0]  THR_RESET = 18'd100000;
    localparam logic [CNT_W-1:0]  GAP_RESET = 32'd10000;

    // result buffer
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PW    = $clog2(OUT_DEPTH);
    localparam int OUT_LW    = $clog2(OUT_DEPTH + 1);

    // per-channel record held in the state memory
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] last;
        logic             flag;
    } t_rec;

    typedef struct packed {
        logic [IN_CH_W-1:0] out_channel;
        logic               detected;
        logic [CNT_W-1:0]   sample_index;
        logic [OSUM_W-1:0]  window_sum;
        logic               buffer_bounced;
        logic [CNT_W-1:0]   last_detect_index;
    } t_result;

endpackage

FILE: sv/wedet_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedet_ram
// generic simple dual-port ram, registered read, read-old on collision
// ----------------------------------------------------------------------------
module wedet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/wedet_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedet_out_fifo
// small result buffer decoupling the update pipeline from the output stall
// ----------------------------------------------------------------------------
module wedet_out_fifo
    import wedet_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_result           i_push_data,
    input  logic              i_stall,
    output logic              o_valid,
    output t_result           o_data,
    output logic [OUT_LW-1:0] o_level
);

    t_result           r_buf [OUT_DEPTH];
    logic [OUT_PW-1:0] r_rd_ptr;
    logic [OUT_PW-1:0] r_wr_ptr;
    logic [OUT_LW-1:0] r_level;
    logic              pop;

    assign pop     = (r_level != '0) && !i_stall;
    assign o_valid = (r_level != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == OUT_PW'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == OUT_PW'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: sv/windowed_energy_onset_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_energy_onset_detector
// per-channel moving sum of sample magnitudes with threshold and debounce
// ----------------------------------------------------------------------------
// path: read stage register, then result buffer, then o_valid; throughput:
//   one beat per cycle while o_stall is low, set by the read-modify-write of
//   the channel record and delay-line memories with a single forwarding stage
// reset: synchronous, active low; clears control state and all entry valid
//   bits, so every memory entry reads as zero until written; no clearing pass
// ----------------------------------------------------------------------------
module windowed_energy_onset_detector
    import wedet_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input sample channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [IN_CH_W-1:0]  i_channel,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                i_last_in_buffer,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [IN_CH_W-1:0]  o_out_channel,
    output logic                o_detected,
    output logic [CNT_W-1:0]    o_sample_index,
    output logic [OSUM_W-1:0]   o_window_sum,
    output logic                o_buffer_bounced,
    output logic [CNT_W-1:0]    o_last_detect_index,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data
);

    localparam logic [CMP_W-1:0] SUM_SAT = CMP_W'({OSUM_W{1'b1}});

    // ---------------------------------------------------------------- config
    logic [THR_W-1:0] r_sum_threshold;
    logic [CNT_W-1:0] r_debounce_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_threshold <= THR_RESET;
            r_debounce_gap  <= GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SUM_THRESHOLD: r_sum_threshold <= i_cfg_data[THR_W-1:0];
                REG_DEBOUNCE_GAP:  r_debounce_gap  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ read stage
    logic              accept;
    logic              in_range;
    logic [CH_W-1:0]   rd_ch;
    logic [POS_W-1:0]  rd_pos;
    logic [DL_AW-1:0]  rd_daddr;
    logic [MAG_W-1:0]  in_mag;
    logic [MAG_W-1:0]  in_ext;

    // write position of each channel's delay line, small enough for flops
    logic [POS_W-1:0]  r_pos [CHANNELS];
    // entry valid bits: an unwritten entry reads as zero
    logic              r_rec_vld [CHANNELS];
    logic              r_dl_vld  [DL_DEPTH];

    assign accept   = i_valid && !o_stall;
    assign in_range = (32'(i_channel) < CHANNELS);
    assign rd_ch    = CH_W'(i_channel);
    assign rd_pos   = in_range ? r_pos[rd_ch] : '0;
    assign rd_daddr = DL_AW'(32'(rd_ch) * WINDOW) + DL_AW'(rd_pos);

    // magnitude in 17 bits so the most negative sample gives 32768
    assign in_ext   = {i_sample[SAMPLE_W-1], i_sample};
    assign in_mag   = i_sample[SAMPLE_W-1] ? (MAG_W'(0) - in_ext) : in_ext;

    logic              r_s1_vld;
    logic [CH_W-1:0]   r_s1_ch;
    logic [DL_AW-1:0]  r_s1_daddr;
    logic [MAG_W-1:0]  r_s1_mag;
    logic              r_s1_last;
    logic              r_s1_rec_vld;
    logic              r_s1_dl_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c] <= '0;
            end
        end else begin
            // out-of-range channels are taken but leave no trace
            r_s1_vld <= accept && in_range;
            if (accept && in_range) begin
                r_pos[rd_ch] <= (rd_pos == POS_W'(WINDOW - 1)) ? '0 : rd_pos + 1'b1;
            end
        end
    end

    // stage payload and the entry valid bits sampled with the ram read
    always_ff @(posedge i_clk) begin
        r_s1_ch      <= rd_ch;
        r_s1_daddr   <= rd_daddr;
        r_s1_mag     <= in_mag;
        r_s1_last    <= i_last_in_buffer;
        r_s1_rec_vld <= in_range ? r_rec_vld[rd_ch] : 1'b0;
        r_s1_dl_vld  <= in_range ? r_dl_vld[rd_daddr] : 1'b0;
    end

    // -------------------------------------------------------------- memories
    t_rec              rec_rdata;
    t_rec              n_rec;
    logic [MAG_W-1:0]  dl_rdata;

    wedet_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (CHANNELS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_ch),
        .i_wdata (n_rec),
        .i_raddr (rd_ch),
        .o_rdata (rec_rdata)
    );

    wedet_ram #(
        .WIDTH (MAG_W),
        .DEPTH (DL_DEPTH)
    ) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_daddr),
        .i_wdata (r_s1_mag),
        .i_raddr (rd_daddr),
        .o_rdata (dl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_rec_vld[c] <= 1'b0;
            end
            for (int e = 0; e < DL_DEPTH; e++) begin
                r_dl_vld[e] <= 1'b0;
            end
        end else if (r_s1_vld) begin
            r_rec_vld[r_s1_ch]   <= 1'b1;
            r_dl_vld[r_s1_daddr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------- update stage
    // the previous beat writes at the same edge this beat was read, so its
    // written record and magnitude are registered and forwarded
    logic              r_fw_vld;
    logic [CH_W-1:0]   r_fw_ch;
    t_rec              r_fw_rec;
    logic [DL_AW-1:0]  r_fw_daddr;
    logic [MAG_W-1:0]  r_fw_mag;

    t_rec              cur;
    logic [MAG_W-1:0]  old_mag;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  since;
    logic              fire;
    logic              flag_acc;
    t_result           res;

    always_comb begin
        if (r_fw_vld && (r_fw_ch == r_s1_ch)) begin
            cur = r_fw_rec;
        end else if (r_s1_rec_vld) begin
            cur = rec_rdata;
        end else begin
            cur = '0;
        end

        if (r_fw_vld && (r_fw_daddr == r_s1_daddr)) begin
            old_mag = r_fw_mag;
        end else if (r_s1_dl_vld) begin
            old_mag = dl_rdata;
        end else begin
            old_mag = '0;
        end

        n_cnt = cur.cnt + 1'b1;
        // sum never goes below the entry it drops, no borrow
        n_sum = cur.sum + SUM_W'(r_s1_mag) - SUM_W'(old_mag);
        since = n_cnt - cur.last;
        fire  = (CMP_W'(n_sum) > CMP_W'(r_sum_threshold)) && (since > r_debounce_gap);

        flag_acc   = cur.flag || fire;
        n_rec.cnt  = n_cnt;
        n_rec.sum  = n_sum;
        n_rec.last = fire ? n_cnt : cur.last;
        // buffer end reports the flag and starts a fresh buffer
        n_rec.flag = r_s1_last ? 1'b0 : flag_acc;

        res.out_channel       = IN_CH_W'(r_s1_ch);
        res.detected          = fire;
        res.sample_index      = n_cnt;
        res.window_sum        = (CMP_W'(n_sum) > SUM_SAT) ? {OSUM_W{1'b1}}
                                                          : OSUM_W'(n_sum);
        res.buffer_bounced    = r_s1_last && flag_acc;
        res.last_detect_index = n_rec.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else begin
            r_fw_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_ch    <= r_s1_ch;
        r_fw_rec   <= n_rec;
        r_fw_daddr <= r_s1_daddr;
        r_fw_mag   <= r_s1_mag;
    end

    // ---------------------------------------------------------------- output
    t_result           out_data;
    logic [OUT_LW-1:0] out_level;

    wedet_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_vld),
        .i_push_data (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_data      (out_data),
        .o_level     (out_level)
    );

    // credit check: buffered beats plus the one in the update stage must
    // leave a slot for a beat taken now, whatever the output side does
    assign o_stall = ((OUT_LW + 1)'(out_level) + (OUT_LW + 1)'(r_s1_vld))
                     > (OUT_LW + 1)'(OUT_DEPTH - 1);

    assign o_out_channel       = out_data.out_channel;
    assign o_detected          = out_data.detected;
    assign o_sample_index      = out_data.sample_index;
    assign o_window_sum        = out_data.window_sum;
    assign o_buffer_bounced    = out_data.buffer_bounced;
    assign o_last_detect_index = out_data.last_detect_index;

endmodule

FILE: sv/wedet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedet_checker
// port-level checks of the onset detector, bound to the top level
// ----------------------------------------------------------------------------
module wedet_checker
    import wedet_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic [IN_CH_W-1:0]  i_channel,
    input logic signed [SAMPLE_W-1:0] i_sample,
    input logic                i_last_in_buffer,
    input logic                o_valid,
    input logic                i_stall,
    input logic [IN_CH_W-1:0]  o_out_channel,
    input logic                o_detected,
    input logic [CNT_W-1:0]    o_sample_index,
    input logic [OSUM_W-1:0]   o_window_sum,
    input logic                o_buffer_bounced,
    input logic [CNT_W-1:0]    o_last_detect_index,
    input logic                i_cfg_we,
    input logic [CFG_IW-1:0]   i_cfg_index,
    input logic [CFG_DW-1:0]   i_cfg_data
);

    // nothing pending straight after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_valid && !o_stall))
        else $error("result or stall visible right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sample_index)
                                  && $stable(o_out_channel) && $stable(o_detected)))
        else $error("stalled result beat changed");

    // a detection records its own sample index
    a_det_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_detected) |-> (o_last_detect_index == o_sample_index))
        else $error("detection index mismatch");

    // a detection needs energy above a non-negative threshold
    a_det_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_detected) |-> (o_window_sum != '0))
        else $error("detection with empty window");

    // results only for channels that exist
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_out_channel) < CHANNELS))
        else $error("result for a channel out of range");

endmodule

bind windowed_energy_onset_detector wedet_checker u_wedet_checker (.*);
